FILE: design/nhe_pkg.sv
`default_nettype none
package nhe_pkg;

  localparam int unsigned XW    = 32;
  localparam int unsigned THW   = 17;
  localparam int unsigned AW    = 48;
  localparam int unsigned SW    = 49;
  localparam int unsigned APW   = 80;
  localparam int unsigned DW    = 98;
  localparam int unsigned TAPW  = 83;
  localparam int unsigned DENW  = 50;
  localparam int unsigned NUMW  = 82;
  localparam int unsigned QW    = 32;
  localparam int unsigned SQ_N  = 49;
  localparam int unsigned DIV_N = 32;
  localparam int unsigned LAT   = 7 + SQ_N + 3 + DIV_N + 1;

  localparam logic [THW-1:0] THETA_ONE = 17'h10000;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_THETA0 = 2'd1,
    ST_SAT    = 2'd2
  } status_t;

  typedef struct packed {
    logic [DW-1:0]  rem;
    logic [SW-1:0]  root;
    logic [APW-1:0] ap;
    logic [SW-1:0]  s;
    logic           tz;
  } sq_stage_t;

  typedef struct packed {
    logic [NUMW-1:0] rem;
    logic [DENW-1:0] den;
    logic [QW-1:0]   q;
    logic            tz;
    logic            dz;
    logic            ovf;
  } div_stage_t;

endpackage
`default_nettype wire

FILE: design/nonrectangular_hyperbola_eval.sv
`default_nettype none
// Each accepted request produces its own out_valid strobe.
// Throughput: one request per cycle; busy is always low.
// The pipeline holds a 49-stage square-root chain and a 32-stage restoring divider.
// The receiver cannot stall; results appear for one cycle only.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
module nonrectangular_hyperbola_eval (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [31:0]            in_light_level,
  input  wire logic [16:0]            in_curvature,
  input  wire logic [31:0]            in_initial_slope,
  input  wire logic [31:0]            in_max_rate,
  output logic                        out_valid,
  output logic [31:0]                 out_response,
  output nhe_pkg::status_t            out_status
);
  import nhe_pkg::*;

  logic [LAT-1:0] vld_r;

  logic [XW-1:0]  x1_r, al1_r, p1_r;
  logic [THW-1:0] th1_r;
  logic           tz1_r;

  logic [AW-1:0]  a2_r;
  logic [SW-1:0]  s2_r;
  logic [XW-1:0]  p2_r;
  logic [THW-1:0] th2_r;
  logic           tz2_r;
  logic [2*XW-1:0] prod_ax;

  logic [63:0]    pp0_r;
  logic [47:0]    pp1_r;
  logic [49:0]    sll_r;
  logic [48:0]    slh_r;
  logic [47:0]    shh_r;
  logic [SW-1:0]  s3_r;
  logic [THW-1:0] th3_r;
  logic           tz3_r;

  logic [APW-1:0] ap4_r;
  logic [DW-1:0]  ss4_r;
  logic [SW-1:0]  s4_r;
  logic [THW-1:0] th4_r;
  logic           tz4_r;

  logic [56:0]    tl5_r, thp5_r;
  logic [APW-1:0] ap5_r;
  logic [DW-1:0]  ss5_r;
  logic [SW-1:0]  s5_r;
  logic           tz5_r;

  logic [TAPW-1:0] tap6_r;
  logic [APW-1:0]  ap6_r;
  logic [DW-1:0]   ss6_r;
  logic [SW-1:0]   s6_r;
  logic            tz6_r;
  logic [96:0]     tap_full;

  sq_stage_t  sq_r [SQ_N+1];
  div_stage_t dv_r [DIV_N+1];

  logic [DENW-1:0] den8_r;
  logic [APW-1:0]  ap8_r;
  logic            tz8_r;

  logic [NUMW-1:0] num9_r;
  logic [DENW-1:0] den9_r;
  logic            tz9_r;

  logic [31:0]     resp_r;
  status_t         stat_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  assign prod_ax  = al1_r * x1_r;
  assign tap_full = {40'd0, tl5_r} + {thp5_r, 40'd0};

  always_ff @(posedge clk) begin
    x1_r  <= in_light_level;
    al1_r <= in_initial_slope;
    p1_r  <= in_max_rate;
    th1_r <= (in_curvature > THETA_ONE) ? THETA_ONE : in_curvature;
    tz1_r <= (in_curvature == '0);

    a2_r  <= prod_ax[63:16];
    s2_r  <= {1'b0, prod_ax[63:16]} + {17'd0, p1_r};
    p2_r  <= p1_r;
    th2_r <= th1_r;
    tz2_r <= tz1_r;

    pp0_r <= a2_r[31:0] * p2_r;
    pp1_r <= a2_r[47:32] * p2_r;
    sll_r <= s2_r[24:0] * s2_r[24:0];
    slh_r <= s2_r[24:0] * s2_r[48:25];
    shh_r <= s2_r[48:25] * s2_r[48:25];
    s3_r  <= s2_r;
    th3_r <= th2_r;
    tz3_r <= tz2_r;

    ap4_r <= {16'd0, pp0_r} + {pp1_r, 32'd0};
    ss4_r <= {48'd0, sll_r} + {23'd0, slh_r, 26'd0} + {shh_r, 50'd0};
    s4_r  <= s3_r;
    th4_r <= th3_r;
    tz4_r <= tz3_r;

    tl5_r  <= th4_r * ap4_r[39:0];
    thp5_r <= th4_r * ap4_r[79:40];
    ap5_r  <= ap4_r;
    ss5_r  <= ss4_r;
    s5_r   <= s4_r;
    tz5_r  <= tz4_r;

    tap6_r <= tap_full[96:14];
    ap6_r  <= ap5_r;
    ss6_r  <= ss5_r;
    s6_r   <= s5_r;
    tz6_r  <= tz5_r;

    sq_r[0].rem  <= ss6_r - {15'd0, tap6_r};
    sq_r[0].root <= '0;
    sq_r[0].ap   <= ap6_r;
    sq_r[0].s    <= s6_r;
    sq_r[0].tz   <= tz6_r;
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    localparam int unsigned B = SQ_N - 1 - j;
    logic [DW+1:0] trial;
    sq_stage_t     sq_nxt;
    assign trial = ({{(DW+2-SW){1'b0}}, sq_r[j].root} << (B + 1))
                 + ({{(DW+1){1'b0}}, 1'b1} << (2 * B));
    always_comb begin
      sq_nxt = sq_r[j];
      if (trial <= {2'b00, sq_r[j].rem}) begin
        sq_nxt.rem  = sq_r[j].rem - trial[DW-1:0];
        sq_nxt.root = sq_r[j].root | (SW'(1) << B);
      end
    end
    always_ff @(posedge clk) begin
      sq_r[j+1] <= sq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den8_r <= {1'b0, sq_r[SQ_N].s} + {1'b0, sq_r[SQ_N].root};
    ap8_r  <= sq_r[SQ_N].ap;
    tz8_r  <= sq_r[SQ_N].tz;

    num9_r <= {1'b0, ap8_r, 1'b0} + {33'd0, den8_r[DENW-1:1]};
    den9_r <= den8_r;
    tz9_r  <= tz8_r;

    dv_r[0].rem <= num9_r;
    dv_r[0].den <= den9_r;
    dv_r[0].q   <= '0;
    dv_r[0].tz  <= tz9_r;
    dv_r[0].dz  <= (den9_r == '0);
    dv_r[0].ovf <= ({1'b0, num9_r} >= {1'b0, den9_r, 32'd0});
  end

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    localparam int unsigned B = DIV_N - 1 - k;
    logic [NUMW:0] dsh;
    div_stage_t    dv_nxt;
    assign dsh = {{(NUMW+1-DENW){1'b0}}, dv_r[k].den} << B;
    always_comb begin
      dv_nxt = dv_r[k];
      if (dsh <= {1'b0, dv_r[k].rem}) begin
        dv_nxt.rem = dv_r[k].rem - dsh[NUMW-1:0];
        dv_nxt.q   = dv_r[k].q | (QW'(1) << B);
      end
    end
    always_ff @(posedge clk) begin
      dv_r[k+1] <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    priority if (dv_r[DIV_N].tz) begin
      resp_r <= '0;
      stat_r <= ST_THETA0;
    end else if (dv_r[DIV_N].dz) begin
      resp_r <= '0;
      stat_r <= ST_OK;
    end else if (dv_r[DIV_N].ovf) begin
      resp_r <= '1;
      stat_r <= ST_SAT;
    end else begin
      resp_r <= dv_r[DIV_N].q;
      stat_r <= ST_OK;
    end
  end

  assign out_valid    = vld_r[LAT-1];
  assign out_response = resp_r;
  assign out_status   = stat_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(LAT) out_valid)
    else $error("request did not produce a result after the pipeline latency");

  a_theta0: assert property (@(posedge clk) disable iff (!rst_n)
    (start && in_curvature == '0) |-> ##(LAT)
      (out_valid && out_status == ST_THETA0 && out_response == '0))
    else $error("zero curvature did not give the zero status");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_SAT) |-> (out_response == '1))
    else $error("saturated result is not all ones");

  a_novld: assert property (@(posedge clk) disable iff (!rst_n)
    (!start) |-> ##(LAT) !out_valid)
    else $error("result strobe without a request");
`endif

endmodule
`default_nettype wire
